/* hw/rtl/timed_duplicate_hash_filter_assert.svh */
// assertion macros for the checker file
`ifndef TIMED_DUPLICATE_HASH_FILTER_ASSERT_SVH
`define TIMED_DUPLICATE_HASH_FILTER_ASSERT_SVH

// clocked assertion, ignored while reset is low
`define TDHF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("tdhf assertion failed");

// clocked assertion that also holds through reset
`define TDHF_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tdhf reset assertion failed");

`endif

/* hw/rtl/tdhf_pkg.sv */
// shared constants, operation codes and cell control types of the duplicate filter
`timescale 1ns / 1ps

package tdhf_pkg;

    localparam int WINDOW_ENTRIES = 8;
    localparam int CNT_W          = $clog2(WINDOW_ENTRIES + 1);

    localparam int HASH_W = 32;
    localparam int TIME_W = 32;
    localparam int OP_W   = 3;
    localparam int AGED_W = 4;
    localparam int ECNT_W = 4;
    localparam int TOT_W  = 32;

    localparam int IN_BITS  = OP_W + HASH_W + TIME_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + AGED_W + ECNT_W + 2 * TOT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] DEFAULT_WINDOW = TIME_W'(1000);

    typedef enum logic [OP_W-1:0] {
        OP_CHECK   = 3'd0,
        OP_ADD     = 3'd1,
        OP_AGE     = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_RST_CNT = 3'd4
    } t_op;

    typedef struct packed {
        logic age;
        logic shift;
        logic clear;
        logic append;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic expired;
        logic expired_last;
        logic match;
        logic first_last;
    } t_cell_stat;

endpackage

/* hw/rtl/tdhf_cell.sv */
// one table slot: stored hash and time, aging compare, match and left shift
`timescale 1ns / 1ps

module tdhf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdhf_pkg::t_cell_ctl           i_ctl,
    input  logic [tdhf_pkg::TIME_W-1:0]   i_window,
    input  logic [tdhf_pkg::TIME_W-1:0]   i_now,
    input  logic [tdhf_pkg::HASH_W-1:0]   i_hash,
    input  logic [tdhf_pkg::HASH_W-1:0]   i_last_hash,
    input  logic [tdhf_pkg::TIME_W-1:0]   i_last_time,
    input  logic                          i_shift_in,
    output logic                          o_shift,
    input  logic                          i_seen,
    output logic                          o_seen,
    input  logic                          i_left_valid,
    input  logic [tdhf_pkg::HASH_W-1:0]   i_nb_hash,
    input  logic [tdhf_pkg::TIME_W-1:0]   i_nb_time,
    input  logic                          i_nb_valid,
    output logic [tdhf_pkg::HASH_W-1:0]   o_hash,
    output logic [tdhf_pkg::TIME_W-1:0]   o_time,
    output tdhf_pkg::t_cell_stat          o_stat
);

    logic                        r_valid;
    logic [tdhf_pkg::HASH_W-1:0] r_hash;
    logic [tdhf_pkg::TIME_W-1:0] r_time;
    logic                        w_expired;
    logic                        w_match;
    logic                        w_is_last;
    logic                        w_load;
    logic [tdhf_pkg::TIME_W-1:0] w_age;

    assign w_age     = i_now - r_time;
    assign w_expired = r_valid && (w_age > i_window);
    assign w_match   = r_valid && (r_hash == i_hash);
    assign w_is_last = (r_time == i_last_time);
    // a hole or a shift further left pulls the right neighbor in
    assign o_shift   = i_ctl.shift && (!r_valid || i_shift_in);
    assign o_seen    = i_seen || w_match;
    // first empty slot takes the appended entry
    assign w_load    = i_ctl.append && !r_valid && i_left_valid;

    assign o_hash = r_hash;
    assign o_time = r_time;

    always_comb begin
        o_stat.valid        = r_valid;
        o_stat.expired      = w_expired;
        o_stat.expired_last = w_expired && w_is_last && (r_hash == i_last_hash);
        o_stat.match        = w_match;
        o_stat.first_last   = w_match && !i_seen && w_is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.age) begin
            if (w_expired) begin
                r_valid <= 1'b0;
            end
        end else if (o_shift) begin
            r_valid <= i_nb_valid;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_shift) begin
            r_hash <= i_nb_hash;
            r_time <= i_nb_time;
        end else if (w_load) begin
            r_hash <= i_hash;
            r_time <= i_now;
        end
    end

endmodule

/* hw/rtl/timed_duplicate_hash_filter.sv */
// top level: operation sequencer, counters and the row of table cells
`timescale 1ns / 1ps

// Timed duplicate hash filter. Holds up to eight frame hashes with their arrival
// times, oldest first, in a row of cells. A check, add or age operation passes
// through an accept step, an aging step in which every cell compares its own age
// against the window, a compaction step in which the entries behind each hole
// move one cell left per cycle until no hole is left, and a step that performs
// the operation and loads the result register, waiting while an untaken result
// still fills it. Clear, counter reset and unused codes go from the accept step
// straight to the last step. The result register lets the next transfer in
// while a result waits. window_length writes of zero store 1000.
module timed_duplicate_hash_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tdhf_pkg::TIME_W-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // op[2:0], hash_value[34:3], now_time[66:35], zero pad
    input  logic [tdhf_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // is_duplicate[0], aged_count[4:1], entry_count[8:5],
    // checked_total[40:9], duplicate_total[72:41], zero pad
    output logic [tdhf_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int N = tdhf_pkg::WINDOW_ENTRIES;

    typedef enum logic [1:0] {
        S_IDLE,
        S_AGE,
        S_COMPACT,
        S_EXEC
    } t_state;

    t_state                          r_state;
    tdhf_pkg::t_op                   r_op;
    logic [tdhf_pkg::HASH_W-1:0]     r_hash;
    logic [tdhf_pkg::TIME_W-1:0]     r_now;
    logic [tdhf_pkg::TIME_W-1:0]     r_window;
    logic [tdhf_pkg::CNT_W-1:0]      r_count;
    logic [tdhf_pkg::CNT_W-1:0]      n_count;
    logic [tdhf_pkg::CNT_W-1:0]      r_aged;
    logic [tdhf_pkg::HASH_W-1:0]     r_last_hash;
    logic [tdhf_pkg::TIME_W-1:0]     r_last_time;
    logic                            r_last_valid;
    logic [tdhf_pkg::TOT_W-1:0]      r_checked;
    logic [tdhf_pkg::TOT_W-1:0]      n_checked;
    logic [tdhf_pkg::TOT_W-1:0]      r_dup_cnt;
    logic [tdhf_pkg::TOT_W-1:0]      n_dup_cnt;
    logic                            n_dup;
    logic                            r_m_valid;
    logic [tdhf_pkg::OUT_W-1:0]      r_m_data;

    tdhf_pkg::t_cell_ctl             w_ctl;
    tdhf_pkg::t_cell_stat            w_stat   [N];
    logic [tdhf_pkg::HASH_W-1:0]     w_hash_q [N];
    logic [tdhf_pkg::TIME_W-1:0]     w_time_q [N];
    logic [N-1:0]                    w_shift;
    logic [N-1:0]                    w_seen;
    logic [N-1:0]                    w_valid;
    logic [N-1:0]                    w_expired;
    logic [N-1:0]                    w_exp_last;
    logic [N-1:0]                    w_match;
    logic [N-1:0]                    w_first_last;

    logic                            w_in_fire;
    logic                            w_exec_fire;
    logic                            w_add_full;
    logic                            w_compacted;
    logic                            w_skip;
    logic [tdhf_pkg::CNT_W-1:0]      w_aged;
    logic [tdhf_pkg::CNT_W-1:0]      w_nmatch;
    logic [tdhf_pkg::CNT_W-1:0]      w_left;
    tdhf_pkg::t_op                   w_in_op;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_exec_fire   = (r_state == S_EXEC) && (!r_m_valid || m_axis_tready);
    assign w_add_full    = w_exec_fire && (r_op == tdhf_pkg::OP_ADD) &&
                           (r_count == tdhf_pkg::CNT_W'(N));
    assign w_in_op       = tdhf_pkg::t_op'(s_axis_tdata[tdhf_pkg::OP_W-1:0]);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        w_ctl.age    = (r_state == S_AGE);
        w_ctl.shift  = ((r_state == S_COMPACT) && !w_compacted) || w_add_full;
        w_ctl.clear  = w_exec_fire && (r_op == tdhf_pkg::OP_CLEAR);
        w_ctl.append = w_exec_fire && (r_op == tdhf_pkg::OP_ADD);
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        logic                        w_shift_in;
        logic                        w_seen_in;
        logic                        w_left_valid;
        logic [tdhf_pkg::HASH_W-1:0] w_nb_hash;
        logic [tdhf_pkg::TIME_W-1:0] w_nb_time;
        logic                        w_nb_valid;

        if (gi == 0) begin : g_head
            assign w_shift_in   = w_add_full;
            assign w_seen_in    = 1'b0;
            assign w_left_valid = 1'b1;
        end else begin : g_body
            assign w_shift_in   = w_shift[gi-1];
            assign w_seen_in    = w_seen[gi-1];
            assign w_left_valid = w_stat[gi-1].valid;
        end

        // the tail cell pulls the new entry in when a full row shifts
        if (gi == N - 1) begin : g_tail
            assign w_nb_hash  = r_hash;
            assign w_nb_time  = r_now;
            assign w_nb_valid = w_add_full;
        end else begin : g_inner
            assign w_nb_hash  = w_hash_q[gi+1];
            assign w_nb_time  = w_time_q[gi+1];
            assign w_nb_valid = w_stat[gi+1].valid;
        end

        tdhf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_window     (r_window),
            .i_now        (r_now),
            .i_hash       (r_hash),
            .i_last_hash  (r_last_hash),
            .i_last_time  (r_last_time),
            .i_shift_in   (w_shift_in),
            .o_shift      (w_shift[gi]),
            .i_seen       (w_seen_in),
            .o_seen       (w_seen[gi]),
            .i_left_valid (w_left_valid),
            .i_nb_hash    (w_nb_hash),
            .i_nb_time    (w_nb_time),
            .i_nb_valid   (w_nb_valid),
            .o_hash       (w_hash_q[gi]),
            .o_time       (w_time_q[gi]),
            .o_stat       (w_stat[gi])
        );

        assign w_valid[gi]      = w_stat[gi].valid;
        assign w_expired[gi]    = w_stat[gi].expired;
        assign w_exp_last[gi]   = w_stat[gi].expired_last;
        assign w_match[gi]      = w_stat[gi].match;
        assign w_first_last[gi] = w_stat[gi].first_last;
    end

    // compacted when no empty cell sits left of a held entry
    always_comb begin
        w_compacted = 1'b1;
        for (int i = 0; i < N - 1; i++) begin
            if (!w_valid[i] && w_valid[i+1]) begin
                w_compacted = 1'b0;
            end
        end
    end

    assign w_aged   = tdhf_pkg::CNT_W'($countones(w_expired));
    assign w_left   = r_count - w_aged;
    assign w_nmatch = tdhf_pkg::CNT_W'($countones(w_match));

    // the entry just added at this same time is passed over once
    assign w_skip = r_last_valid && (r_hash == r_last_hash) &&
                    (r_now == r_last_time) && (|w_first_last);

    always_comb begin
        n_dup     = 1'b0;
        n_checked = r_checked;
        n_dup_cnt = r_dup_cnt;
        n_count   = r_count;
        unique case (r_op)
            tdhf_pkg::OP_CHECK: begin
                n_checked = r_checked + 1'b1;
                n_dup     = (w_nmatch != '0) &&
                            !(w_skip && (w_nmatch == tdhf_pkg::CNT_W'(1)));
                if (n_dup) begin
                    n_dup_cnt = r_dup_cnt + 1'b1;
                end
            end
            tdhf_pkg::OP_ADD: begin
                if (r_count != tdhf_pkg::CNT_W'(N)) begin
                    n_count = r_count + 1'b1;
                end
            end
            tdhf_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            tdhf_pkg::OP_RST_CNT: begin
                n_checked = '0;
                n_dup_cnt = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= tdhf_pkg::DEFAULT_WINDOW;
        end else if (i_cfg_we) begin
            r_window <= (i_cfg_wdata == '0) ? tdhf_pkg::DEFAULT_WINDOW : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_last_valid <= 1'b0;
            r_checked    <= '0;
            r_dup_cnt    <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (w_exec_fire) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_aged <= '0;
                        r_op   <= w_in_op;
                        r_hash <= s_axis_tdata[tdhf_pkg::OP_W +: tdhf_pkg::HASH_W];
                        r_now  <= s_axis_tdata[tdhf_pkg::OP_W + tdhf_pkg::HASH_W +:
                                               tdhf_pkg::TIME_W];
                        if (w_in_op == tdhf_pkg::OP_CHECK || w_in_op == tdhf_pkg::OP_ADD ||
                            w_in_op == tdhf_pkg::OP_AGE) begin
                            r_state <= S_AGE;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_AGE: begin
                    r_aged  <= w_aged;
                    r_count <= w_left;
                    if ((|w_exp_last) || (w_left == '0)) begin
                        r_last_valid <= 1'b0;
                    end
                    r_state <= S_COMPACT;
                end
                S_COMPACT: begin
                    if (w_compacted) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_exec_fire) begin
                        r_count   <= n_count;
                        r_checked <= n_checked;
                        r_dup_cnt <= n_dup_cnt;
                        r_m_data  <= {
                            (tdhf_pkg::OUT_W - tdhf_pkg::OUT_BITS)'(0),
                            n_dup_cnt,
                            n_checked,
                            tdhf_pkg::ECNT_W'(n_count),
                            tdhf_pkg::AGED_W'(r_aged),
                            n_dup
                        };
                        unique case (r_op)
                            tdhf_pkg::OP_CHECK: begin
                                if (w_skip) begin
                                    r_last_valid <= 1'b0;
                                end
                            end
                            tdhf_pkg::OP_ADD: begin
                                r_last_hash  <= r_hash;
                                r_last_time  <= r_now;
                                r_last_valid <= 1'b1;
                            end
                            tdhf_pkg::OP_CLEAR: begin
                                r_last_hash  <= '0;
                                r_last_time  <= '0;
                                r_last_valid <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/tdhf_checker.sv */
// port level checks of the duplicate filter, bound to the top level
`timescale 1ns / 1ps
`include "timed_duplicate_hash_filter_assert.svh"

module tdhf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [tdhf_pkg::OUT_W-1:0] m_axis_tdata
);

    // a held result stays offered until taken
    `TDHF_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    // no result is offered right after reset
    `TDHF_ASSERT_RST(a_rst_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // one item at a time: input closes after a transfer
    `TDHF_ASSERT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // table never reports more entries than cells
    `TDHF_ASSERT(a_count_max, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[8:5] <= 4'd8)

endmodule

bind timed_duplicate_hash_filter tdhf_checker u_tdhf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
